[src/thadc_pkg.sv]
// shared constants, widths and resistance table for the thermistor converter
package thadc_pkg;

  localparam int DEF_TABLE_ENTRIES  = 211;
  localparam int DEF_ADC_FULL_SCALE = 4095;

  localparam int DVD_W     = 40;  // divider dividend and quotient width
  localparam int DVS_W     = 24;  // divider divisor width
  localparam int RES_W     = 23;
  localparam int TEMP_W    = 15;
  localparam int TEMP_IW   = 17;  // internal temperature width before wrap
  localparam int LISTED    = 211;
  localparam int BASE_CENTI = -6000;
  localparam logic [RES_W-1:0] COLD_RES = 23'd6006000;

  typedef enum logic [1:0] {
    REG_REF_MV   = 2'd0,
    REG_FIXED_R  = 2'd1,
    REG_LOW_SIDE = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    FLAG_INSIDE = 2'd0,
    FLAG_HOT    = 2'd1,
    FLAG_COLD   = 2'd2
  } range_flag_t;

  localparam logic [RES_W-1:0] RTAB [0:LISTED-1] = '{
    23'd6006000, 23'd5637000, 23'd5294000, 23'd4974000, 23'd4677000, 23'd4400000,
    23'd4142000, 23'd3900000, 23'd3675000, 23'd3465000, 23'd3269000, 23'd3085000,
    23'd2913000, 23'd2752000, 23'd2601000, 23'd2460000, 23'd2328000, 23'd2203000,
    23'd2087000, 23'd1977000, 23'd1874000, 23'd1775000, 23'd1682000, 23'd1594000,
    23'd1511000, 23'd1434000, 23'd1361000, 23'd1292000, 23'd1228000, 23'd1167000,
    23'd1109000, 23'd1054000, 23'd1001000, 23'd952200, 23'd905700, 23'd861800,
    23'd820400, 23'd781300, 23'd744400, 23'd709400, 23'd676400, 23'd644400,
    23'd614200, 23'd585700, 23'd558700, 23'd533100, 23'd508800, 23'd485900,
    23'd464100, 23'd443500, 23'd423900, 23'd405000, 23'd387000, 23'd370000,
    23'd353800, 23'd338500, 23'd323900, 23'd310000, 23'd296900, 23'd284400,
    23'd272500, 23'd261000, 23'd250000, 23'd239600, 23'd229700, 23'd220300,
    23'd211300, 23'd202800, 23'd194600, 23'd186900, 23'd179500, 23'd172300,
    23'd165500, 23'd159000, 23'd152700, 23'd146800, 23'd141100, 23'd135700,
    23'd130500, 23'd125600, 23'd120900, 23'd116300, 23'd112000, 23'd107800,
    23'd103800, 23'd100000, 23'd96330, 23'd92810, 23'd89450, 23'd86230,
    23'd83140, 23'd80160, 23'd77300, 23'd74560, 23'd71930, 23'd69410,
    23'd67000, 23'd64680, 23'd62460, 23'd60330, 23'd58290, 23'd56300,
    23'd54400, 23'd52570, 23'd50810, 23'd49120, 23'd47500, 23'd45940,
    23'd44440, 23'd43000, 23'd41620, 23'd40270, 23'd38970, 23'd37730,
    23'd36530, 23'd35370, 23'd34260, 23'd33190, 23'd32160, 23'd31170,
    23'd30220, 23'd29290, 23'd28390, 23'd27530, 23'd26700, 23'd25890,
    23'd25120, 23'd24380, 23'd23660, 23'd22960, 23'd22290, 23'd21640,
    23'd21010, 23'd20400, 23'd19810, 23'd19250, 23'd18700, 23'd18170,
    23'd17660, 23'd17160, 23'd16690, 23'd16220, 23'd15770, 23'd15340,
    23'd14920, 23'd14510, 23'd14120, 23'd13740, 23'd13370, 23'd13010,
    23'd12660, 23'd12330, 23'd12000, 23'd11690, 23'd11380, 23'd11080,
    23'd10800, 23'd10520, 23'd10250, 23'd9990, 23'd9737, 23'd9490,
    23'd9250, 23'd9018, 23'd8793, 23'd8574, 23'd8363, 23'd8157,
    23'd7958, 23'd7764, 23'd7576, 23'd7392, 23'd7214, 23'd7041,
    23'd6873, 23'd6710, 23'd6552, 23'd6398, 23'd6248, 23'd6103,
    23'd5961, 23'd5823, 23'd5689, 23'd5559, 23'd5432, 23'd5309,
    23'd5189, 23'd5072, 23'd4959, 23'd4849, 23'd4741, 23'd4636,
    23'd4534, 23'd4435, 23'd4338, 23'd4243, 23'd4152, 23'd4062,
    23'd3975, 23'd3890, 23'd3808, 23'd3727, 23'd3648, 23'd3572,
    23'd3497, 23'd3424, 23'd3353, 23'd3284, 23'd3217, 23'd3151,
    23'd3087
  };

  // entries past the listed ones read as zero
  function automatic logic [RES_W-1:0] rtab_lookup(input logic [7:0] idx);
    logic [RES_W-1:0] v;
    v = '0;
    if (int'(idx) < LISTED) v = RTAB[idx];
    return v;
  endfunction

endpackage

[src/thadc_divider.sv]
// restoring divider, one quotient bit per cycle
module thadc_divider import thadc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DVS_W:0]   shifted;

  always_comb begin
    shifted = {rem_r, quo_r[DVD_W-1]};
    if (shifted >= {1'b0, dvs_r}) begin
      rem_nxt = DVS_W'(shifted - {1'b0, dvs_r});
      quo_nxt = {quo_r[DVD_W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[DVS_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvs_r  <= divisor;
        rem_r  <= '0;
        quo_r  <= dividend;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[src/thermistor_adc_to_temperature_core.sv]
// thermistor divider count to temperature: top level with control sequencer
// One count is converted at a time and the next count is accepted only once
// the previous one has left the sequencer. The count is scaled to millivolts
// by a registered product and a reciprocal multiply. The resistance and the
// interpolation fraction each take one pass through the shared bit-serial
// divider. The table is scanned from the cold end at one interval per
// cycle. A count whose node voltage is zero or full scale skips the
// resistance divide, and one whose resistance clamps skips the table scan.
// A finished result sits in the output register while the next count is
// already accepted.
module thermistor_adc_to_temperature_core import thadc_pkg::*; #(
  parameter int TABLE_ENTRIES  = DEF_TABLE_ENTRIES,
  parameter int ADC_FULL_SCALE = DEF_ADC_FULL_SCALE
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // adc_count[11:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // temperature_centi_c[14:0], resistance_deci_ohms[37:15]
  output logic [1:0]  out_tuser,  // range_flag[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  localparam logic [RES_W-1:0]   HOT_RES   = rtab_lookup(8'(TABLE_ENTRIES - 1));
  localparam logic [TEMP_IW-1:0] HOT_TEMP  = TEMP_IW'(BASE_CENTI + (TABLE_ENTRIES - 1) * 100);
  localparam logic [TEMP_IW-1:0] BASE_TEMP = TEMP_IW'(BASE_CENTI);
  // count*ref fits 25 bits, so this rounded-up reciprocal gives the exact quotient
  localparam int          MV_SH    = 25 + $clog2(ADC_FULL_SCALE);
  localparam logic [26:0] MV_RECIP = 27'(((longint'(1) << MV_SH) +
                                          longint'(ADC_FULL_SCALE) - 1) /
                                         longint'(ADC_FULL_SCALE));

  typedef enum logic [3:0] {
    S_IDLE, S_MV, S_MV_W, S_R, S_R_W, S_CLAMP, S_SEARCH, S_FRAC_W, S_FINISH
  } state_t;
  state_t state_r;

  logic [12:0]        ref_r;
  logic [19:0]        rf_r;
  logic               low_r;
  logic [11:0]        count_r;
  logic [24:0]        prod_r;
  logic [24:0]        mv_r;
  logic [DVD_W-1:0]   r_r;
  logic [7:0]         idx_r;
  logic [TEMP_IW-1:0] temp_r;
  logic [1:0]         flag_r;
  logic               out_valid_r;
  logic [TEMP_W-1:0]  out_temp_r;
  logic [RES_W-1:0]   out_res_r;
  logic [1:0]         out_flag_r;

  logic             div_start, div_done;
  logic [DVD_W-1:0] div_dvd, div_q;
  logic [DVS_W-1:0] div_dvs;

  logic [23:0]      rf10;
  logic [12:0]      diff, mv13;
  logic [RES_W-1:0] t1, t2, span, gap;
  logic [8:0]       idx_next;
  logic [51:0]      mv_prod;
  logic [24:0]      mv_calc;
  logic             out_load;

  assign rf10     = {rf_r, 3'b000} + {3'b000, rf_r, 1'b0};
  assign mv13     = mv_r[12:0];
  assign diff     = ref_r - mv13;
  assign t1       = rtab_lookup(idx_r);
  assign idx_next = {1'b0, idx_r} + 9'd1;
  assign t2       = rtab_lookup(idx_next[7:0]);
  assign span     = t1 - t2;
  assign gap      = t1 - r_r[RES_W-1:0];
  assign mv_prod  = 52'(prod_r) * 52'(MV_RECIP);
  assign mv_calc  = 25'(mv_prod >> MV_SH);
  assign out_load = (state_r == S_FINISH) && (!out_valid_r || out_tready);

  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    unique case (state_r)
      S_R: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(rf10) * DVD_W'(low_r ? mv13 : diff);
        div_dvs   = DVS_W'(low_r ? diff : mv13);
      end
      S_SEARCH: begin
        div_start = (int'(idx_next) < TABLE_ENTRIES) && (r_r[RES_W-1:0] <= t1) &&
                    (r_r[RES_W-1:0] >= t2) && (span != '0);
        div_dvd   = DVD_W'(gap) * DVD_W'(100);
        div_dvs   = DVS_W'(span);
      end
      default: ;
    endcase
  end

  thadc_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ref_r       <= 13'd3300;
      rf_r        <= 20'd10000;
      low_r       <= 1'b1;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_REF_MV:   ref_r <= cfg_data[12:0];
          REG_FIXED_R:  rf_r  <= cfg_data;
          REG_LOW_SIDE: low_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            count_r <= in_tdata[11:0];
            state_r <= S_MV;
          end
        end
        S_MV: begin
          prod_r  <= 25'(count_r) * 25'(ref_r);
          state_r <= S_MV_W;
        end
        S_MV_W: begin
          mv_r <= mv_calc;
          if (mv_calc == '0) begin
            r_r     <= DVD_W'(HOT_RES);
            state_r <= S_CLAMP;
          end else if (mv_calc >= 25'(ref_r)) begin
            r_r     <= DVD_W'(COLD_RES);
            state_r <= S_CLAMP;
          end else begin
            state_r <= S_R;
          end
        end
        S_R: state_r <= S_R_W;
        S_R_W: begin
          if (div_done) begin
            r_r     <= div_q;
            state_r <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          idx_r  <= '0;
          temp_r <= HOT_TEMP;
          if (r_r >= DVD_W'(COLD_RES)) begin
            r_r     <= DVD_W'(COLD_RES);
            temp_r  <= BASE_TEMP;
            flag_r  <= FLAG_COLD;
            state_r <= S_FINISH;
          end else if (r_r <= DVD_W'(HOT_RES)) begin
            r_r     <= DVD_W'(HOT_RES);
            flag_r  <= FLAG_HOT;
            state_r <= S_FINISH;
          end else begin
            flag_r  <= FLAG_INSIDE;
            state_r <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (int'(idx_next) >= TABLE_ENTRIES) begin
            state_r <= S_FINISH;
          end else if (r_r[RES_W-1:0] <= t1 && r_r[RES_W-1:0] >= t2) begin
            temp_r <= BASE_TEMP + TEMP_IW'(idx_r) * TEMP_IW'(100);
            state_r <= (span == '0) ? S_FINISH : S_FRAC_W;
          end else begin
            idx_r <= idx_next[7:0];
          end
        end
        S_FRAC_W: begin
          if (div_done) begin
            temp_r  <= temp_r + TEMP_IW'(div_q[6:0]);
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_load) begin
            out_temp_r  <= temp_r[TEMP_W-1:0];
            out_res_r   <= r_r[RES_W-1:0];
            out_flag_r  <= flag_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r, out_temp_r};
  assign out_tuser  = out_flag_r;

endmodule
